>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check helpers for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// sc2a_pkg
// beat types, scan code constants and the letter decode for the translator
// ----------------------------------------------------------------------------
package sc2a_pkg;

	typedef enum logic {
		CMD_SCAN = 1'b0,
		CMD_POP  = 1'b1
	} sc2a_cmd_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] scan_byte;
	} sc2a_in_t;

	typedef struct packed {
		logic [6:0] char_out;
		logic       char_valid;
		logic       was_empty;
		logic       pushed;
		logic       dropped;
	} sc2a_out_t;

	localparam logic [7:0] SC_SHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] SC_BREAK_BIT   = 8'h80;
	localparam logic [7:0] SC_SHIFT_BREAK = SC_SHIFT_MAKE | SC_BREAK_BIT;
	localparam logic [7:0] SC_RETURN      = 8'h1C;
	localparam logic [7:0] SC_SPACE       = 8'h39;

	localparam logic [6:0] CH_NONE     = 7'h00;
	localparam logic [6:0] CH_NEWLINE  = 7'h0A;
	localparam logic [6:0] CH_SPACE    = 7'h20;
	localparam logic [6:0] CASE_OFFSET = 7'h20;

	// lower case letter for a set 1 make code, CH_NONE when not a letter
	function automatic logic [6:0] letter_of(input logic [7:0] code);
		logic [6:0] ch;
		case (code)
			8'h10: ch = 7'h71; // q
			8'h11: ch = 7'h77; // w
			8'h12: ch = 7'h65; // e
			8'h13: ch = 7'h72; // r
			8'h14: ch = 7'h74; // t
			8'h15: ch = 7'h79; // y
			8'h16: ch = 7'h75; // u
			8'h17: ch = 7'h69; // i
			8'h18: ch = 7'h6F; // o
			8'h19: ch = 7'h70; // p
			8'h1E: ch = 7'h61; // a
			8'h1F: ch = 7'h73; // s
			8'h20: ch = 7'h64; // d
			8'h21: ch = 7'h66; // f
			8'h22: ch = 7'h67; // g
			8'h23: ch = 7'h68; // h
			8'h24: ch = 7'h6A; // j
			8'h25: ch = 7'h6B; // k
			8'h26: ch = 7'h6C; // l
			8'h2C: ch = 7'h7A; // z
			8'h2D: ch = 7'h78; // x
			8'h2E: ch = 7'h63; // c
			8'h2F: ch = 7'h76; // v
			8'h30: ch = 7'h62; // b
			8'h31: ch = 7'h6E; // n
			8'h32: ch = 7'h6D; // m
			default: ch = CH_NONE;
		endcase
		return ch;
	endfunction

endpackage

>>> rtl/scancode_to_ascii_fifo.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo
// set 1 scan code to ascii translator feeding a ring character fifo
// ----------------------------------------------------------------------------
// Each input beat is either a keyboard scan code (cmd = 0) or a pop request
// (cmd = 1) and yields exactly one result beat. Shift make/break track the
// shift state, return and space give newline and space, and the 26 letter
// make codes give lower or upper case letters; every other code gives an
// all-zero result. Characters go into a ring fifo of FIFO_DEPTH slots that
// holds at most FIFO_DEPTH-1 characters; a push into a full fifo is dropped
// and flagged, a pop on an empty fifo is flagged. An item is taken every
// cycle while item_ready is high, and its result appears in the next
// cycle: the decode, the pointer update and the single read port of the
// character memory all finish in the accepting cycle, and the memory read
// data lands in the result register. item_ready only drops while a result
// waits and result_ready is low. The character memory has no reset and
// needs no clearing pass, since only written slots are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scancode_to_ascii_fifo
	import sc2a_pkg::*;
#(
	parameter int FIFO_DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  sc2a_in_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output sc2a_out_t result
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

	// fifo state
	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q;
	logic             shift_q;
	logic [6:0]       char_mem [FIFO_DEPTH];

	// result register
	logic       res_valid_q;
	logic [6:0] rd_data_q;
	logic       char_valid_q, was_empty_q, pushed_q, dropped_q;

	// decode
	logic             accept;
	logic             is_pop, is_shift_make, is_shift_break;
	logic [6:0]       letter, ch;
	logic             fifo_empty, fifo_full;
	logic [PTR_W-1:0] rd_ptr_nxt, wr_ptr_nxt;
	logic             do_pop, do_push, do_drop;

	// the result register frees up when it is empty or being drained
	assign item_ready = !res_valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	assign is_pop         = (item.cmd == CMD_POP);
	assign is_shift_make  = (item.scan_byte == SC_SHIFT_MAKE);
	assign is_shift_break = (item.scan_byte == SC_SHIFT_BREAK);

	assign rd_ptr_nxt = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
	assign wr_ptr_nxt = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
	assign fifo_empty = (rd_ptr_q == wr_ptr_q);
	assign fifo_full  = (wr_ptr_nxt == rd_ptr_q);

	// character produced by a scan beat, CH_NONE when the code is ignored
	always_comb begin
		letter = letter_of(item.scan_byte);
		if (item.scan_byte == SC_RETURN) begin
			ch = CH_NEWLINE;
		end else if (item.scan_byte == SC_SPACE) begin
			ch = CH_SPACE;
		end else if (letter != CH_NONE && shift_q) begin
			ch = letter - CASE_OFFSET;
		end else begin
			ch = letter;
		end
	end

	assign do_pop  = is_pop && !fifo_empty;
	assign do_push = !is_pop && (ch != CH_NONE) && !fifo_full;
	assign do_drop = !is_pop && (ch != CH_NONE) && fifo_full;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			shift_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept && do_pop) begin
				rd_ptr_q <= rd_ptr_nxt;
			end
			if (accept && do_push) begin
				wr_ptr_q <= wr_ptr_nxt;
			end
			if (accept && !is_pop && is_shift_make) begin
				shift_q <= 1'b1;
			end else if (accept && !is_pop && is_shift_break) begin
				shift_q <= 1'b0;
			end
		end
	end

	// character memory, at most one write or one registered read per beat
	always_ff @(posedge clk) begin
		if (accept && do_push) begin
			char_mem[wr_ptr_q] <= ch;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && do_pop) begin
			rd_data_q <= char_mem[rd_ptr_q];
		end
	end

	// result flags, loaded with each accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			char_valid_q <= do_pop;
			was_empty_q  <= is_pop && fifo_empty;
			pushed_q     <= do_push;
			dropped_q    <= do_drop;
		end
	end

	assign result_valid      = res_valid_q;
	assign result.char_out   = char_valid_q ? rd_data_q : CH_NONE;
	assign result.char_valid = char_valid_q;
	assign result.was_empty  = was_empty_q;
	assign result.pushed     = pushed_q;
	assign result.dropped    = dropped_q;

	// a result carries at most one outcome
	`ASSERT_SAME(a_one_outcome, clk, arst_n, res_valid_q,
		$onehot0({char_valid_q, was_empty_q, pushed_q, dropped_q}))
	// a pop on a non-empty fifo returns a character next cycle
	`ASSERT_NEXT(a_pop_returns, clk, arst_n, accept && is_pop && !fifo_empty,
		res_valid_q && char_valid_q)
	// a stored push moves the write pointer
	`ASSERT_NEXT(a_push_moves, clk, arst_n, accept && do_push,
		wr_ptr_q != $past(wr_ptr_q))
	// stored characters are never zero
	`ASSERT_SAME(a_char_nonzero, clk, arst_n, res_valid_q && char_valid_q,
		rd_data_q != CH_NONE)

endmodule
